[hw/rtl/lde_pkg.sv]
package lde_pkg;

    // fixed field widths
    localparam int LDE_SMP_BITS     = 16;
    localparam int LDE_DUR_BITS     = 24;
    localparam int LDE_FRAME_BITS   = 32;
    localparam int LDE_CFG_IDX_BITS = 3;

    // register indexes
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_DELAY   = 3'd0;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_ATTACK  = 3'd1;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_DECAY   = 3'd2;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_SUSTAIN = 3'd3;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_RELEASE = 3'd4;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_PEAK    = 3'd5;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_HOLD    = 3'd6;
    localparam logic [LDE_CFG_IDX_BITS-1:0] CFG_MODE    = 3'd7;

    // reset heights, Q1.15
    localparam logic signed [LDE_SMP_BITS-1:0] LDE_PEAK_RST = 16'sd32767;
    localparam logic signed [LDE_SMP_BITS-1:0] LDE_HOLD_RST = 16'sd16384;

    // input word
    typedef struct packed {
        logic [LDE_FRAME_BITS-1:0]      frame_index;
        logic signed [LDE_SMP_BITS-1:0] sample_in;
        logic                           block_end;
    } t_in;

    // output word
    typedef struct packed {
        logic signed [LDE_SMP_BITS-1:0] sample_out;
        logic                           envelope_done;
        logic                           block_end_out;
    } t_out;

    // sideband carried along the divider cells
    typedef struct packed {
        logic                           vld;
        logic                           neg;
        logic signed [LDE_SMP_BITS-1:0] base;
        logic                           mode;
        logic signed [LDE_SMP_BITS-1:0] smp;
        logic                           done;
        logic                           bend;
    } t_side;

endpackage

[hw/rtl/lde_div_cell.sv]
module lde_div_cell #(
    parameter int DURATION_BITS = lde_pkg::LDE_DUR_BITS,
    parameter int QUOT_BITS     = lde_pkg::LDE_SMP_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  lde_pkg::t_side           i_side,
    input  logic [DURATION_BITS-1:0] i_rem,
    input  logic [QUOT_BITS-1:0]     i_lq,
    input  logic [DURATION_BITS-1:0] i_len,
    output lde_pkg::t_side           o_side,
    output logic [DURATION_BITS-1:0] o_rem,
    output logic [QUOT_BITS-1:0]     o_lq,
    output logic [DURATION_BITS-1:0] o_len
);

    logic [DURATION_BITS:0]   trial;
    logic [DURATION_BITS:0]   diff;
    logic                     ge;
    logic [DURATION_BITS-1:0] n_rem;
    logic [QUOT_BITS-1:0]     n_lq;
    lde_pkg::t_side           r_side;
    logic [DURATION_BITS-1:0] r_rem;
    logic [QUOT_BITS-1:0]     r_lq;
    logic [DURATION_BITS-1:0] r_len;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {i_rem, i_lq[QUOT_BITS-1]};
        diff  = trial - {1'b0, i_len};
        ge    = (trial >= {1'b0, i_len});
        n_rem = ge ? diff[DURATION_BITS-1:0] : trial[DURATION_BITS-1:0];
        n_lq  = {i_lq[QUOT_BITS-2:0], ge};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else if (i_en) begin
            r_side.vld <= i_side.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.neg  <= i_side.neg;
            r_side.base <= i_side.base;
            r_side.mode <= i_side.mode;
            r_side.smp  <= i_side.smp;
            r_side.done <= i_side.done;
            r_side.bend <= i_side.bend;
            r_rem       <= n_rem;
            r_lq        <= n_lq;
            r_len       <= i_len;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_lq   = r_lq;
    assign o_len  = r_len;

endmodule

[hw/rtl/linear_dadsr_envelope_core.sv]
// channel | direction | handshake             | word
// input   | in        | i_in_valid/o_in_stall | lde_pkg::t_in
// output  | out       | o_out_valid/i_out_stall | lde_pkg::t_out
// config  | in        | i_cfg_we (no wait)    | i_cfg_idx, i_cfg_data
//
// one word per cycle sustained while the output is not stalled; a word passes stages
// 0-2, the row of divider cells (one quotient bit per cell), then stages 3-5.
// segment bounds are kept as running sums, updated in the same edge as a length write.
// reset is synchronous and active low; it clears valids and loads register defaults.
// a stalled output only stops stages that are full; empty stages keep filling.
module linear_dadsr_envelope_core #(
    parameter int DURATION_BITS = lde_pkg::LDE_DUR_BITS
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_in_valid,
    output logic                                                  o_in_stall,
    input  lde_pkg::t_in                                          i_in_data,
    output logic                                                  o_out_valid,
    input  logic                                                  i_out_stall,
    output lde_pkg::t_out                                         o_out_data,
    input  logic                                                  i_cfg_we,
    input  logic [lde_pkg::LDE_CFG_IDX_BITS-1:0]                  i_cfg_idx,
    input  logic [((DURATION_BITS > lde_pkg::LDE_SMP_BITS) ?
                   DURATION_BITS : lde_pkg::LDE_SMP_BITS)-1:0]    i_cfg_data
);

    localparam int S  = lde_pkg::LDE_SMP_BITS;
    localparam int D  = DURATION_BITS;
    localparam int QW = S + 1;
    localparam int PW = QW + D;
    localparam int BW = D + 3;
    localparam int FW = lde_pkg::LDE_FRAME_BITS;
    localparam int CW = (BW > FW) ? BW : FW;

    // configuration
    logic [D-1:0]          r_len [0:4];
    logic [BW-1:0]         r_bnd [0:4];
    logic signed [S-1:0]   r_peak;
    logic signed [S-1:0]   r_hold;
    logic                  r_mode;
    logic [D:0]            len_delta;
    logic [BW-1:0]         bnd_delta;

    // length writes move every bound from that segment on by the change
    always_comb begin
        len_delta = {1'b0, i_cfg_data[D-1:0]} - {1'b0, r_len[i_cfg_idx]};
        bnd_delta = BW'($signed(len_delta));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_len[k] <= '0;
                r_bnd[k] <= '0;
            end
            r_peak <= lde_pkg::LDE_PEAK_RST;
            r_hold <= lde_pkg::LDE_HOLD_RST;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lde_pkg::CFG_DELAY, lde_pkg::CFG_ATTACK, lde_pkg::CFG_DECAY,
                lde_pkg::CFG_SUSTAIN, lde_pkg::CFG_RELEASE: begin
                    r_len[i_cfg_idx] <= i_cfg_data[D-1:0];
                    for (int k = 0; k < 5; k++) begin
                        if (k >= int'(i_cfg_idx)) begin
                            r_bnd[k] <= r_bnd[k] + bnd_delta;
                        end
                    end
                end
                lde_pkg::CFG_PEAK: r_peak <= $signed(i_cfg_data[S-1:0]);
                lde_pkg::CFG_HOLD: r_hold <= $signed(i_cfg_data[S-1:0]);
                lde_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage enables, back to front
    logic en0, en1, en2, en3, en4, en5;
    logic c_en [0:QW-1];

    // stage 0: take the word and compare against the bounds
    logic           r0_vld;
    logic [FW-1:0]  r0_f;
    logic signed [S-1:0] r0_smp;
    logic           r0_bend;
    logic [4:0]     r0_lt;
    logic [4:0]     n0_lt;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n0_lt[k] = (CW'(i_in_data.frame_index) < CW'(r_bnd[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en0) begin
            r0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_f    <= i_in_data.frame_index;
            r0_smp  <= i_in_data.sample_in;
            r0_bend <= i_in_data.block_end;
            r0_lt   <= n0_lt;
        end
    end

    // stage 1: pick the segment, its height, offset and length
    lde_pkg::t_side  n1_side, r1_side;
    logic signed [S:0] pk_x, hd_x, h;
    logic [CW-1:0]   ofs_w;
    logic [BW-1:0]   seg_base;
    logic            use_ramp;
    logic [S:0]      n1_mag, r1_mag;
    logic [D-1:0]    n1_off, r1_off, n1_len, r1_len;

    always_comb begin
        pk_x          = {r_peak[S-1], r_peak};
        hd_x          = {r_hold[S-1], r_hold};
        n1_side.vld   = r0_vld;
        n1_side.mode  = r_mode;
        n1_side.smp   = r0_smp;
        n1_side.bend  = r0_bend;
        n1_side.done  = !r0_lt[4];
        n1_side.base  = '0;
        h             = '0;
        seg_base      = '0;
        use_ramp      = 1'b0;
        n1_len        = {{(D-1){1'b0}}, 1'b1};
        priority if (r0_lt[0]) begin
            n1_side.base = '0;
        end else if (r0_lt[1]) begin
            h        = pk_x;
            seg_base = r_bnd[0];
            n1_len   = r_len[1];
            use_ramp = 1'b1;
        end else if (r0_lt[2]) begin
            n1_side.base = r_peak;
            h        = hd_x - pk_x;
            seg_base = r_bnd[1];
            n1_len   = r_len[2];
            use_ramp = 1'b1;
        end else if (r0_lt[3]) begin
            n1_side.base = r_hold;
        end else if (r0_lt[4]) begin
            n1_side.base = r_hold;
            h        = -hd_x;
            seg_base = r_bnd[3];
            n1_len   = r_len[4];
            use_ramp = 1'b1;
        end else begin
            n1_side.base = '0;
        end
        n1_side.neg = h[S];
        n1_mag      = h[S] ? 17'(-h) : h;
        ofs_w       = CW'(r0_f) - CW'(seg_base);
        n1_off      = use_ramp ? ofs_w[D-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.vld <= 1'b0;
        end else if (en1) begin
            r1_side.vld <= n1_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_side.neg  <= n1_side.neg;
            r1_side.base <= n1_side.base;
            r1_side.mode <= n1_side.mode;
            r1_side.smp  <= n1_side.smp;
            r1_side.done <= n1_side.done;
            r1_side.bend <= n1_side.bend;
            r1_mag       <= n1_mag;
            r1_off       <= n1_off;
            r1_len       <= n1_len;
        end
    end

    // stage 2: height magnitude times offset
    lde_pkg::t_side r2_side;
    logic [PW-1:0]  r2_prod;
    logic [D-1:0]   r2_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.vld <= 1'b0;
        end else if (en2) begin
            r2_side.vld <= r1_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_side.neg  <= r1_side.neg;
            r2_side.base <= r1_side.base;
            r2_side.mode <= r1_side.mode;
            r2_side.smp  <= r1_side.smp;
            r2_side.done <= r1_side.done;
            r2_side.bend <= r1_side.bend;
            r2_prod      <= PW'(r1_mag) * PW'(r1_off);
            r2_len       <= r1_len;
        end
    end

    // row of divider cells, one quotient bit each
    lde_pkg::t_side c_side [0:QW-1];
    logic [D-1:0]   c_rem  [0:QW-1];
    logic [QW-1:0]  c_lq   [0:QW-1];
    logic [D-1:0]   c_len  [0:QW-1];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_cell
            if (g == QW - 1) begin : g_last
                assign c_en[g] = !c_side[g].vld || en3;
            end else begin : g_mid
                assign c_en[g] = !c_side[g].vld || c_en[g+1];
            end
            if (g == 0) begin : g_first
                lde_div_cell #(.DURATION_BITS(D), .QUOT_BITS(QW)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_en   (c_en[g]),
                    .i_side (r2_side),
                    .i_rem  (r2_prod[PW-1:QW]),
                    .i_lq   (r2_prod[QW-1:0]),
                    .i_len  (r2_len),
                    .o_side (c_side[g]),
                    .o_rem  (c_rem[g]),
                    .o_lq   (c_lq[g]),
                    .o_len  (c_len[g])
                );
            end else begin : g_next
                lde_div_cell #(.DURATION_BITS(D), .QUOT_BITS(QW)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_en   (c_en[g]),
                    .i_side (c_side[g-1]),
                    .i_rem  (c_rem[g-1]),
                    .i_lq   (c_lq[g-1]),
                    .i_len  (c_len[g-1]),
                    .o_side (c_side[g]),
                    .o_rem  (c_rem[g]),
                    .o_lq   (c_lq[g]),
                    .o_len  (c_len[g])
                );
            end
        end
    endgenerate

    // stage 3: level = segment base plus signed quotient
    logic                r3_vld, r3_mode, r3_done, r3_bend;
    logic signed [S-1:0] r3_smp, r3_lev;
    logic signed [S+1:0] q_x, lev_w;

    always_comb begin
        q_x   = $signed({1'b0, c_lq[QW-1]});
        lev_w = (S+2)'(c_side[QW-1].base) + (c_side[QW-1].neg ? -q_x : q_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en3) begin
            r3_vld <= c_side[QW-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_mode <= c_side[QW-1].mode;
            r3_done <= c_side[QW-1].done;
            r3_bend <= c_side[QW-1].bend;
            r3_smp  <= c_side[QW-1].smp;
            r3_lev  <= lev_w[S-1:0];
        end
    end

    // stage 4: sample times level
    logic                  r4_vld, r4_mode, r4_done, r4_bend;
    logic signed [S-1:0]   r4_lev;
    logic signed [2*S-1:0] r4_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en4) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_mode <= r3_mode;
            r4_done <= r3_done;
            r4_bend <= r3_bend;
            r4_lev  <= r3_lev;
            r4_p    <= r3_smp * r3_lev;
        end
    end

    // stage 5: shift and saturate the product, or pass the level, and hold the output word
    logic                r5_vld;
    lde_pkg::t_out       r5_out;
    logic signed [S:0]   sh;
    logic signed [S-1:0] sat;
    lde_pkg::t_out       n5_out;

    always_comb begin
        sh = r4_p[2*S-1:S-1];
        if (sh[S] != sh[S-1]) begin
            sat = sh[S] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
        end else begin
            sat = sh[S-1:0];
        end
        n5_out.sample_out    = r4_mode ? sat : r4_lev;
        n5_out.envelope_done = r4_done;
        n5_out.block_end_out = r4_bend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en5) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_out <= n5_out;
        end
    end

    // enable chain
    assign en5 = !r5_vld || !i_out_stall;
    assign en4 = !r4_vld || en5;
    assign en3 = !r3_vld || en4;
    assign en2 = !r2_side.vld || c_en[0];
    assign en1 = !r1_side.vld || en2;
    assign en0 = !r0_vld || en1;

    assign o_in_stall  = !en0;
    assign o_out_valid = r5_vld;
    assign o_out_data  = r5_out;

    // a finished envelope gives silence
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.envelope_done |-> o_out_data.sample_out == '0)
        else $error("done word with nonzero sample");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // running bounds never go backwards
    a_bnd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bnd[0] <= r_bnd[1] && r_bnd[1] <= r_bnd[2] &&
        r_bnd[2] <= r_bnd[3] && r_bnd[3] <= r_bnd[4])
        else $error("segment bounds out of order");

    // input only held back when the whole pipe is full behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r0_vld && r4_vld))
        else $error("input stalled with room in the pipe");

endmodule

[tb/sv/tb_linear_dadsr_envelope_core.sv]
module tb_linear_dadsr_envelope_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUR_W      = lde_pkg::LDE_DUR_BITS;
    localparam int PIPE_DRAIN = 40;
    localparam int IDLE_LIMIT = 4000;
    localparam longint DUR_MAX = (64'd1 << DUR_W) - 1;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    lde_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    lde_pkg::t_out o_out_data;
    logic          i_cfg_we;
    logic [lde_pkg::LDE_CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [DUR_W-1:0]                     i_cfg_data;

    // own copy of the register file
    longint seg_len [5];
    longint peak_lvl;
    longint hold_lvl;
    bit     mul_mode;

    lde_pkg::t_out level_q [$];
    int     err_cnt;
    int     hold_off;
    int     hold_used;
    int     stall_left;
    int     idle_cnt;
    bit     no_gaps;

    linear_dadsr_envelope_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // truncated ramp term h * i / len
    function automatic longint ramp_term(longint h, longint i, longint len);
        longint mag;
        longint q;
        mag = (h < 0) ? -h : h;
        q   = (mag * i) / len;
        return (h < 0) ? -q : q;
    endfunction

    // envelope level, gated sample and done flag for one frame
    function automatic lde_pkg::t_out predict_envelope(lde_pkg::t_in w);
        longint f;
        longint tot;
        longint b;
        longint lvl;
        longint y;
        lde_pkg::t_out r;
        f   = longint'({32'b0, w.frame_index});
        tot = seg_len[0] + seg_len[1] + seg_len[2] + seg_len[3] + seg_len[4];
        y   = 0;
        if (f < tot) begin
            b = seg_len[0];
            if (f < b) begin
                lvl = 0;
            end else if (f < b + seg_len[1]) begin
                lvl = ramp_term(peak_lvl, f - b, seg_len[1]);
            end else if (f < b + seg_len[1] + seg_len[2]) begin
                b   = b + seg_len[1];
                lvl = peak_lvl - ramp_term(peak_lvl - hold_lvl, f - b, seg_len[2]);
            end else if (f < b + seg_len[1] + seg_len[2] + seg_len[3]) begin
                lvl = hold_lvl;
            end else begin
                b   = b + seg_len[1] + seg_len[2] + seg_len[3];
                lvl = hold_lvl - ramp_term(hold_lvl, f - b, seg_len[4]);
            end
            if (mul_mode) begin
                // floor shift then clamp to Q1.15
                y = (longint'(w.sample_in) * lvl) >>> 15;
                if (y > 32767)
                    y = 32767;
                if (y < -32768)
                    y = -32768;
            end else begin
                y = lvl;
            end
        end
        r.sample_out    = y[15:0];
        r.envelope_done = (f >= tot);
        r.block_end_out = w.block_end;
        return r;
    endfunction

    task automatic report(string what, longint exp_v, longint got_v);
        $display("error: %s expected %0d got %0d", what, exp_v, got_v);
        err_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        lde_pkg::t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_q.size() == 0) begin
                report("unexpected word", 0, 1);
            end else begin
                e = level_q.pop_front();
                if (o_out_data.sample_out !== e.sample_out)
                    report("sample_out", e.sample_out, o_out_data.sample_out);
                if (o_out_data.envelope_done !== e.envelope_done)
                    report("envelope_done", e.envelope_done, o_out_data.envelope_done);
                if (o_out_data.block_end_out !== e.block_end_out)
                    report("block_end_out", e.block_end_out, o_out_data.block_end_out);
            end
        end
    end

    // receiver stalls, with long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
            hold_used   = 0;
        end else if (hold_used < hold_off) begin
            hold_used   = hold_used + 1;
            i_out_stall <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall)
                stall_left = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall_left > 0) begin
                stall_left  = stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cnt = 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cnt = 0;
            else
                idle_cnt = idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("linear_dadsr_envelope_core: mismatch");
                $finish;
            end
        end
    end

    // send one word, waiting a random gap first
    task automatic send_word(logic [31:0] frame, logic signed [15:0] smp, logic bend);
        int           gap;
        lde_pkg::t_in w;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.frame_index = frame;
        w.sample_in   = smp;
        w.block_end   = bend;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do
            @(posedge i_clk);
        while (o_in_stall);
        level_q.insert(level_q.size(), predict_envelope(w));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // register write; the caller must write only once the pipe is empty, this task does not wait
    task automatic write_reg(logic [lde_pkg::LDE_CFG_IDX_BITS-1:0] idx,
                             logic [DUR_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lde_pkg::CFG_DELAY:   seg_len[0] = val;
            lde_pkg::CFG_ATTACK:  seg_len[1] = val;
            lde_pkg::CFG_DECAY:   seg_len[2] = val;
            lde_pkg::CFG_SUSTAIN: seg_len[3] = val;
            lde_pkg::CFG_RELEASE: seg_len[4] = val;
            lde_pkg::CFG_PEAK:    peak_lvl   = longint'($signed(val[15:0]));
            lde_pkg::CFG_HOLD:    hold_lvl   = longint'($signed(val[15:0]));
            lde_pkg::CFG_MODE:    mul_mode   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_shape(longint d, longint a, longint dc, longint s, longint r,
                             logic [15:0] pk, logic [15:0] hd, bit m);
        drain();
        write_reg(lde_pkg::CFG_DELAY, d[DUR_W-1:0]);
        write_reg(lde_pkg::CFG_ATTACK, a[DUR_W-1:0]);
        write_reg(lde_pkg::CFG_DECAY, dc[DUR_W-1:0]);
        write_reg(lde_pkg::CFG_SUSTAIN, s[DUR_W-1:0]);
        write_reg(lde_pkg::CFG_RELEASE, r[DUR_W-1:0]);
        write_reg(lde_pkg::CFG_PEAK, {8'b0, pk});
        write_reg(lde_pkg::CFG_HOLD, {8'b0, hd});
        write_reg(lde_pkg::CFG_MODE, {23'b0, m});
    endtask

    function automatic longint pick_len();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return DUR_MAX;
            2:       return $urandom_range(0, DUR_MAX);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // all lengths zero after reset: every frame is past the end
    task automatic test_reset_state();
        send_word(32'd0, 16'sh7fff, 1'b1);
        send_word(32'hffff_ffff, 16'sh8000, 1'b0);
        send_word(32'd5, 16'sh1234, 1'b1);
    endtask

    // sweep across every segment, then saturation and wide lengths
    task automatic test_segments();
        set_shape(3, 4, 5, 2, 6, 16'h7fff, 16'h8000, 1'b0);
        for (int f = 0; f < 21; f++)
            send_word(f, 16'sh0, f[0]);
        // minus full scale times minus full scale clamps
        set_shape(0, 1, 4, 0, 3, 16'h8000, 16'h7fff, 1'b1);
        send_word(32'd1, 16'sh8000, 1'b1);
        send_word(32'd2, 16'sh7fff, 1'b0);
        // widest lengths, sums past 24 bits
        set_shape(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 16'h7fff, 16'h4000, 1'b0);
        send_word(32'd83886074, 16'sh0, 1'b0);
        send_word(32'd83886075, 16'sh0, 1'b1);
        send_word(32'd41943040, 16'sh0, 1'b0);
        send_word(32'hffff_ffff, 16'sh0, 1'b1);
    endtask

    // random shapes with frames mostly inside the envelope
    task automatic test_random();
        longint tot;
        longint f;
        for (int ph = 0; ph < 6; ph++) begin
            set_shape(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                      pick_height(), pick_height(), 1'($urandom_range(0, 1)));
            no_gaps = (ph == 2);
            tot = seg_len[0] + seg_len[1] + seg_len[2] + seg_len[3] + seg_len[4];
            for (int n = 0; n < 110; n++) begin
                if ($urandom_range(0, 7) == 0)
                    f = $urandom;
                else
                    f = $urandom_range(0, 32'((tot > 1000000) ? 1000000 : tot + 4));
                if (tot > 1000000 && $urandom_range(0, 3) == 0)
                    f = tot - $urandom_range(0, 1000);
                send_word(f[31:0], 16'($urandom), 1'($urandom_range(0, 1)));
            end
            no_gaps = 1'b0;
        end
    endtask

    // long receiver hold-off so the pipe fills and stalls the input
    task automatic test_backpressure();
        set_shape(2, 7, 9, 5, 11, 16'h6000, 16'h2000, 1'b1);
        hold_off = hold_off + 150;
        no_gaps  = 1'b1;
        for (int n = 0; n < 60; n++)
            send_word($urandom_range(0, 40), 16'($urandom), 1'($urandom_range(0, 1)));
        no_gaps = 1'b0;
    endtask

    initial begin
        err_cnt    = 0;
        hold_off   = 0;
        no_gaps    = 1'b0;
        seg_len    = '{0, 0, 0, 0, 0};
        peak_lvl   = 32767;
        hold_lvl   = 16384;
        mul_mode   = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= lde_pkg::CFG_DELAY;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_segments();
        test_random();
        test_backpressure();
        drain();

        if (err_cnt == 0)
            $display("linear_dadsr_envelope_core: match");
        else
            $display("linear_dadsr_envelope_core: mismatch");
        $finish;
    end

endmodule

[linear_dadsr_envelope_core.f]
hw/rtl/lde_pkg.sv
hw/rtl/lde_div_cell.sv
hw/rtl/linear_dadsr_envelope_core.sv
tb/sv/tb_linear_dadsr_envelope_core.sv
